@@ rtl/core/vn_pkg.sv @@
package vn_pkg;

    localparam int COMP_WIDTH     = 16;
    localparam int UNIT_FRAC_BITS = 14;
    localparam int UNIT_WIDTH     = 16;
    localparam int LEN_WIDTH      = 16;

endpackage

@@ rtl/core/vn_front.sv @@
module vn_front #(
    parameter int W = vn_pkg::COMP_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic signed [W-1:0] vec_x,
    input  logic signed [W-1:0] vec_y,
    input  logic signed [W-1:0] vec_z,
    output logic                out_valid,
    output logic [2*W-1:0]      sum,
    output logic [2:0][W-1:0]   mag,
    output logic [2:0]          neg
);

    logic [2:0][W-1:0]   mag1_reg, mag2_reg, mag3_reg;
    logic [2:0]          neg1_reg, neg2_reg, neg3_reg;
    logic [2:0][2*W-1:0] sqr_reg;
    logic [2*W-1:0]      sum_reg;
    logic                v1_reg, v2_reg, v3_reg;
    logic [2:0][W-1:0]   mag_next;
    logic [2:0]          neg_next;
    logic [2:0][W-1:0]   raw;

    assign raw = {vec_z, vec_y, vec_x};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg_next[i] = raw[i][W-1];
            // most negative value maps to 2^(W-1), which fits unsigned
            mag_next[i] = neg_next[i] ? (~raw[i] + W'(1)) : raw[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag1_reg <= mag_next;
            neg1_reg <= neg_next;
            for (int i = 0; i < 3; i++)
                sqr_reg[i] <= (2*W)'(mag1_reg[i]) * (2*W)'(mag1_reg[i]);
            mag2_reg <= mag1_reg;
            neg2_reg <= neg1_reg;
            sum_reg  <= sqr_reg[0] + sqr_reg[1] + sqr_reg[2];
            mag3_reg <= mag2_reg;
            neg3_reg <= neg2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign sum       = sum_reg;
    assign mag       = mag3_reg;
    assign neg       = neg3_reg;

endmodule

@@ rtl/core/vn_sqrt_step.sv @@
module vn_sqrt_step #(
    parameter int W      = vn_pkg::COMP_WIDTH,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [W+1:0]      rem_in,
    input  logic [W-1:0]      root_in,
    input  logic [2*W-1:0]    rest_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [W+1:0]      rem_out,
    output logic [W-1:0]      root_out,
    output logic [2*W-1:0]    rest_out,
    output logic [SIDE_W-1:0] side_out
);

    logic              valid_reg;
    logic [W+1:0]      rem_reg, rem_next;
    logic [W-1:0]      root_reg, root_next;
    logic [2*W-1:0]    rest_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [W+3:0]      cur, trial;

    // one root bit: bring down two radicand bits, try (root << 2) | 1
    always_comb
    begin
        cur   = {rem_in, rest_in[2*W-1 -: 2]};
        trial = {2'b00, root_in, 2'b01};
        if (cur >= trial)
        begin
            rem_next  = (W+2)'(cur - trial);
            root_next = {root_in[W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = cur[W+1:0];
            root_next = {root_in[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            rest_reg <= {rest_in[2*W-3:0], 2'b00};
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign rest_out  = rest_reg;
    assign side_out  = side_reg;

endmodule

@@ rtl/core/vn_div_step.sv @@
module vn_div_step #(
    parameter int W      = vn_pkg::COMP_WIDTH,
    parameter int F      = vn_pkg::UNIT_FRAC_BITS,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [W-1:0]      divisor,
    input  logic [2:0][W-1:0] rem_in,
    input  logic [2:0][F:0]   rest_in,
    input  logic [2:0][F:0]   quo_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [W-1:0]      divisor_out,
    output logic [2:0][W-1:0] rem_out,
    output logic [2:0][F:0]   rest_out,
    output logic [2:0][F:0]   quo_out,
    output logic [SIDE_W-1:0] side_out
);

    logic              valid_reg;
    logic [W-1:0]      div_reg;
    logic [2:0][W-1:0] rem_reg, rem_next;
    logic [2:0][F:0]   rest_reg, quo_reg, quo_next;
    logic [SIDE_W-1:0] side_reg;
    logic [2:0][W:0]   cur;

    // restoring division, one quotient bit per lane
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cur[i] = {rem_in[i], rest_in[i][F]};
            if (cur[i] >= {1'b0, divisor})
            begin
                rem_next[i] = W'(cur[i] - {1'b0, divisor});
                quo_next[i] = {quo_in[i][F-1:0], 1'b1};
            end
            else
            begin
                rem_next[i] = cur[i][W-1:0];
                quo_next[i] = {quo_in[i][F-1:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg  <= divisor;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            side_reg <= side_in;
            for (int i = 0; i < 3; i++)
                rest_reg[i] <= {rest_in[i][F-1:0], 1'b0};
        end
    end

    assign out_valid   = valid_reg;
    assign divisor_out = div_reg;
    assign rem_out     = rem_reg;
    assign rest_out    = rest_reg;
    assign quo_out     = quo_reg;
    assign side_out    = side_reg;

endmodule

@@ rtl/core/vector3_normalize.sv @@
// channel | valid     | stall     | payload
// --------+-----------+-----------+-------------------------------------------
// in      | in_valid  | in_stall  | vec_x, vec_y, vec_z
// out     | out_valid | out_stall | unit_x, unit_y, unit_z, vec_length, is_zero
//
// One request per cycle while not stalled. Stages: 3 front stages (abs,
// square, sum), one stage per root bit, one per quotient bit, one output
// register.
// Reset clears only the valid bits. A stall at the output while out_valid is
// high freezes the whole pipeline; in_stall follows it.
module vector3_normalize #(
    parameter int COMP_WIDTH     = vn_pkg::COMP_WIDTH,
    parameter int UNIT_FRAC_BITS = vn_pkg::UNIT_FRAC_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COMP_WIDTH-1:0] vec_x,
    input  logic signed [COMP_WIDTH-1:0] vec_y,
    input  logic signed [COMP_WIDTH-1:0] vec_z,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [vn_pkg::UNIT_WIDTH-1:0] unit_x,
    output logic signed [vn_pkg::UNIT_WIDTH-1:0] unit_y,
    output logic signed [vn_pkg::UNIT_WIDTH-1:0] unit_z,
    output logic [vn_pkg::LEN_WIDTH-1:0] vec_length,
    output logic                         is_zero
);

    localparam int W   = COMP_WIDTH;
    localparam int F   = UNIT_FRAC_BITS;
    localparam int UW  = vn_pkg::UNIT_WIDTH;
    localparam int LW  = vn_pkg::LEN_WIDTH;
    localparam int SSW = 3*W + 4;        // mags, signs, zero flag
    localparam int DSW = 4;              // signs, zero flag
    localparam int XW  = (F + 2 > UW) ? F + 2 : UW;
    localparam int XL  = (W > LW) ? W : LW;

    logic adv;

    logic              f_valid;
    logic [2*W-1:0]    f_sum;
    logic [2:0][W-1:0] f_mag;
    logic [2:0]        f_neg;

    logic              s_valid [0:W];
    logic [W+1:0]      s_rem   [0:W];
    logic [W-1:0]      s_root  [0:W];
    logic [2*W-1:0]    s_rest  [0:W];
    logic [SSW-1:0]    s_side  [0:W];

    logic              d_valid [0:F+1];
    logic [W-1:0]      d_div   [0:F+1];
    logic [2:0][W-1:0] d_rem   [0:F+1];
    logic [2:0][F:0]   d_rest  [0:F+1];
    logic [2:0][F:0]   d_quo   [0:F+1];
    logic [DSW-1:0]    d_side  [0:F+1];

    logic [2:0][W-1:0] s_mag_end;

    logic                 out_valid_reg;
    logic [2:0][UW-1:0]   unit_reg, unit_next;
    logic [LW-1:0]        len_reg;
    logic                 zero_reg;
    logic [XW-1:0]        q_ext;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    vn_front #(.W(W)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (in_valid),
        .vec_x    (vec_x),
        .vec_y    (vec_y),
        .vec_z    (vec_z),
        .out_valid(f_valid),
        .sum      (f_sum),
        .mag      (f_mag),
        .neg      (f_neg)
    );

    assign s_valid[0] = f_valid;
    assign s_rem[0]   = '0;
    assign s_root[0]  = '0;
    assign s_rest[0]  = f_sum;
    assign s_side[0]  = {(f_sum == '0), f_neg, f_mag};

    for (genvar i = 0; i < W; i++)
    begin : g_sqrt
        vn_sqrt_step #(.W(W), .SIDE_W(SSW)) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .in_valid (s_valid[i]),
            .rem_in   (s_rem[i]),
            .root_in  (s_root[i]),
            .rest_in  (s_rest[i]),
            .side_in  (s_side[i]),
            .out_valid(s_valid[i+1]),
            .rem_out  (s_rem[i+1]),
            .root_out (s_root[i+1]),
            .rest_out (s_rest[i+1]),
            .side_out (s_side[i+1])
        );
    end

    assign s_mag_end = s_side[W][3*W-1:0];

    // quotient never exceeds 2^F, so its top W-1 bits are zero: preload mag >> 1
    for (genvar i = 0; i < 3; i++)
    begin : g_div_load
        assign d_rem[0][i]  = {1'b0, s_mag_end[i][W-1:1]};
        assign d_rest[0][i] = {s_mag_end[i][0], F'(0)};
        assign d_quo[0][i]  = '0;
    end

    assign d_valid[0] = s_valid[W];
    assign d_div[0]   = s_root[W];
    assign d_side[0]  = s_side[W][SSW-1:3*W];

    for (genvar i = 0; i <= F; i++)
    begin : g_div
        vn_div_step #(.W(W), .F(F), .SIDE_W(DSW)) u_step (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (adv),
            .in_valid   (d_valid[i]),
            .divisor    (d_div[i]),
            .rem_in     (d_rem[i]),
            .rest_in    (d_rest[i]),
            .quo_in     (d_quo[i]),
            .side_in    (d_side[i]),
            .out_valid  (d_valid[i+1]),
            .divisor_out(d_div[i+1]),
            .rem_out    (d_rem[i+1]),
            .rest_out   (d_rest[i+1]),
            .quo_out    (d_quo[i+1]),
            .side_out   (d_side[i+1])
        );
    end

    always_comb
    begin
        q_ext = '0;
        for (int i = 0; i < 3; i++)
        begin
            q_ext = XW'(d_quo[F+1][i]);
            if (d_side[F+1][i])
                q_ext = ~q_ext + XW'(1);
            unit_next[i] = d_side[F+1][3] ? '0 : q_ext[UW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= d_valid[F+1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            unit_reg <= unit_next;
            len_reg  <= LW'(XL'(d_div[F+1]));
            zero_reg <= d_side[F+1][3];
        end
    end

    assign out_valid  = out_valid_reg;
    assign unit_x     = unit_reg[0];
    assign unit_y     = unit_reg[1];
    assign unit_z     = unit_reg[2];
    assign vec_length = len_reg;
    assign is_zero    = zero_reg;

endmodule

@@ sim/tb_vector3_normalize.sv @@
`timescale 1ns / 100ps

module tb_vector3_normalize;

    localparam int CW  = vn_pkg::COMP_WIDTH;
    localparam int FB  = vn_pkg::UNIT_FRAC_BITS;
    localparam int UWD = vn_pkg::UNIT_WIDTH;
    localparam int LWD = vn_pkg::LEN_WIDTH;
    localparam int LATENCY = CW + FB + 5;
    localparam int N_RANDOM = 730;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } vec_t;

    typedef struct packed {
        logic signed [UWD-1:0] ux;
        logic signed [UWD-1:0] uy;
        logic signed [UWD-1:0] uz;
        logic [LWD-1:0]        len;
        logic                  zero;
    } unit_vec_t;

    // directed row: vector, flag for a typed-in result, the result itself
    typedef struct {
        vec_t      v;
        bit        fixed;
        unit_vec_t res;
    } row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [CW-1:0] vec_x, vec_y, vec_z;
    logic out_valid;
    logic out_stall;
    logic signed [UWD-1:0] unit_x, unit_y, unit_z;
    logic [LWD-1:0] vec_length;
    logic is_zero;

    unit_vec_t normalized_q[$];
    int errors;
    int n_sent;
    int n_checked;
    int n_zero_seen;
    bit quiet;
    bit hold_off;

    vector3_normalize i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .vec_x     (vec_x),
        .vec_y     (vec_y),
        .vec_z     (vec_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .unit_x    (unit_x),
        .unit_y    (unit_y),
        .unit_z    (unit_z),
        .vec_length(vec_length),
        .is_zero   (is_zero)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint unsigned isqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        for (int i = 31; i >= 0; i--)
        begin
            b = root | (64'd1 << i);
            if (b * b <= n)
                root = b;
        end
        return root;
    endfunction

    function automatic logic [UWD-1:0] unit_of(
        logic signed [CW-1:0] c, longint unsigned len);
        longint signed cv;
        longint unsigned mag;
        longint unsigned q;
        cv = c;
        mag = (cv < 0) ? -cv : cv;
        q = (mag << FB) / len;
        if (cv < 0)
            q = -q;
        return q[UWD-1:0];
    endfunction

    function automatic unit_vec_t normalize(vec_t v);
        unit_vec_t r;
        longint signed ax, ay, az;
        longint unsigned sq, len;
        ax = v.x;
        ay = v.y;
        az = v.z;
        sq = ax * ax + ay * ay + az * az;
        r = '0;
        if (sq == 0)
        begin
            r.zero = 1'b1;
            return r;
        end
        len = isqrt(sq);
        r.ux = unit_of(v.x, len);
        r.uy = unit_of(v.y, len);
        r.uz = unit_of(v.z, len);
        r.len = len[LWD-1:0];
        return r;
    endfunction

    function automatic logic signed [CW-1:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            1: return $signed(16'($urandom_range(0, 15))) - 16'sd8;
            2: return $signed(16'($urandom_range(0, 511))) - 16'sd256;
            default: return $signed(16'($urandom()));
        endcase
    endfunction

    // in_valid stays high between back-to-back requests; dropped only to idle
    task automatic send(vec_t v, bit fixed, unit_vec_t res);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid <= 1'b1;
        vec_x <= v.x;
        vec_y <= v.y;
        vec_z <= v.z;
        normalized_q.push_back(fixed ? res : normalize(v));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n_sent++;
        @(negedge clk);
    endtask

    // receiver side: random stalls, plus a long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (3 * LATENCY) @(negedge clk);
                hold_off = 1'b0;
                out_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        unit_vec_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (normalized_q.size() == 0)
            begin
                $display("%0t: unexpected result %h %h %h len %h zero %b", $time,
                         unit_x, unit_y, unit_z, vec_length, is_zero);
                errors++;
            end
            else
            begin
                want = normalized_q.pop_front();
                n_checked++;
                if (is_zero)
                    n_zero_seen++;
                if (unit_x !== want.ux)
                begin
                    $display("%0t: unit_x expected %h actual %h", $time, want.ux, unit_x);
                    errors++;
                end
                if (unit_y !== want.uy)
                begin
                    $display("%0t: unit_y expected %h actual %h", $time, want.uy, unit_y);
                    errors++;
                end
                if (unit_z !== want.uz)
                begin
                    $display("%0t: unit_z expected %h actual %h", $time, want.uz, unit_z);
                    errors++;
                end
                if (vec_length !== want.len)
                begin
                    $display("%0t: vec_length expected %h actual %h", $time, want.len,
                             vec_length);
                    errors++;
                end
                if (is_zero !== want.zero)
                begin
                    $display("%0t: is_zero expected %b actual %b", $time, want.zero, is_zero);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("FAIL vector3_normalize");
        $finish;
    end

    initial
    begin
        row_t dir[$];
        vec_t v;
        int wait_cycles;
        rst_n = 1'b0;
        in_valid = 1'b0;
        vec_x = '0;
        vec_y = '0;
        vec_z = '0;
        errors = 0;
        n_sent = 0;
        n_checked = 0;
        n_zero_seen = 0;
        quiet = 1'b0;
        hold_off = 1'b0;

        // zero vector, single full-scale axes, all-extreme mixes, small and odd cases
        dir.push_back('{'{16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b1}});
        dir.push_back('{'{16'sh7fff, 16'sd0, 16'sd0}, 1'b1,
                        '{16'sd16384, 16'sd0, 16'sd0, 16'h7fff, 1'b0}});
        dir.push_back('{'{16'sd0, 16'sh8000, 16'sd0}, 1'b1,
                        '{16'sd0, -16'sd16384, 16'sd0, 16'h8000, 1'b0}});
        dir.push_back('{'{16'sd0, 16'sd0, 16'sh8000}, 1'b1,
                        '{16'sd0, 16'sd0, -16'sd16384, 16'h8000, 1'b0}});
        dir.push_back('{'{16'sd1, 16'sd0, 16'sd0}, 1'b1,
                        '{16'sd16384, 16'sd0, 16'sd0, 16'd1, 1'b0}});
        dir.push_back('{'{16'sd0, 16'sd0, -16'sd1}, 1'b1,
                        '{16'sd0, 16'sd0, -16'sd16384, 16'd1, 1'b0}});
        dir.push_back('{'{16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, '0});
        dir.push_back('{'{16'sh7fff, 16'sh7fff, 16'sh7fff}, 1'b0, '0});
        dir.push_back('{'{16'sh7fff, 16'sh8000, 16'sh7fff}, 1'b0, '0});
        dir.push_back('{'{16'sd1, 16'sd1, 16'sd1}, 1'b0, '0});
        dir.push_back('{'{-16'sd1, 16'sd1, -16'sd1}, 1'b0, '0});
        dir.push_back('{'{16'sd3, 16'sd4, 16'sd0}, 1'b0, '0});
        dir.push_back('{'{16'sd256, -16'sd256, 16'sd256}, 1'b0, '0});
        dir.push_back('{'{16'sh5555, 16'shaaaa, 16'sh0f0f}, 1'b0, '0});
        dir.push_back('{'{16'shffff, 16'sh0001, 16'sh7fff}, 1'b0, '0});

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir[i])
            send(dir[i].v, dir[i].fixed, dir[i].res);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == 200)
                hold_off = 1'b1;   // sender keeps offering while output is held
            if (i == N_RANDOM - 150)
                quiet = 1'b1;
            if ($urandom_range(0, 49) == 0)
                v = '0;
            else
            begin
                v.x = rand_comp();
                v.y = rand_comp();
                v.z = rand_comp();
            end
            send(v, 1'b0, '0);
        end
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (normalized_q.size() != 0 && wait_cycles < 100 * LATENCY)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (LATENCY + 5) @(posedge clk);

        $display("Sent %0d vectors (directed extremes, zero vectors, random mixes);", n_sent);
        $display("checked %0d results, %0d zero-length, with stalls and a long hold-off.",
                 n_checked, n_zero_seen);
        if (errors == 0 && normalized_q.size() == 0)
            $display("PASS vector3_normalize");
        else
            $display("FAIL vector3_normalize");
        $finish;
    end

endmodule
